// File: rtl/sfp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the scale frame parser.
// No dependencies; used by the front end, back end and top of the parser.
package sfp_pkg;

  localparam int unsigned IDX_W = 5;

  localparam logic [7:0] STX_BYTE = 8'h02;

  localparam logic [IDX_W-1:0] STATUS_POS   = 5'd2;
  localparam logic [IDX_W-1:0] WEIGHT_FIRST = 5'd4;
  localparam logic [IDX_W-1:0] WEIGHT_LAST  = 5'd9;
  localparam logic [IDX_W-1:0] TARE_FIRST   = 5'd10;
  localparam logic [IDX_W-1:0] TARE_LAST    = 5'd15;

  localparam logic [7:0] ST_MOTION_A = 8'h68;
  localparam logic [7:0] ST_MOTION_B = 8'h78;
  localparam logic [7:0] ST_OVER_A   = 8'h7C;
  localparam logic [7:0] ST_OVER_B   = 8'h6C;
  localparam logic [7:0] ST_POUNDS   = 8'h60;
  localparam logic [7:0] ST_KILOS    = 8'h70;

  localparam logic [1:0] UNIT_LB   = 2'd0;
  localparam logic [1:0] UNIT_KG   = 2'd1;
  localparam logic [1:0] UNIT_KEEP = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       status;
    logic       weight;
    logic       tare;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  sum7;
    logic        checksum_bad;
    logic [15:0] bad_frames;
    logic        frame_rejected;
    logic [1:0]  unit_code;
    logic [47:0] weight_digits;
    logic [47:0] tare_digits;
  } res_t;

  function automatic logic is_rejected(input logic [7:0] s);
    return (s == ST_MOTION_A) || (s == ST_MOTION_B) || (s == ST_OVER_A) || (s == ST_OVER_B);
  endfunction

  function automatic logic [1:0] unit_of(input logic [7:0] s);
    logic [1:0] u;
    u = UNIT_KEEP;
    if (s == ST_POUNDS) begin
      u = UNIT_LB;
    end else if (s == ST_KILOS) begin
      u = UNIT_KG;
    end
    return u;
  endfunction

endpackage

// File: rtl/sfp_fifo.sv
`timescale 1ns / 1ps
// Small register queue with push/full and pop/empty sides.
// No dependencies; holds commands and results inside the parser.
module sfp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/sfp_front.sv
`timescale 1ns / 1ps
// Front end: hunts for the start byte, tracks the frame position and
// tags each frame byte with its role. Depends on sfp_pkg.
module sfp_front
  import sfp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 18
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] rx_byte_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(FRAME_BYTES - 1);

  logic             collecting_q, collecting_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             is_stx;

  assign is_stx = (rx_byte_i == STX_BYTE);

  always_comb begin
    cmd_o.data   = rx_byte_i;
    cmd_o.start  = !collecting_q;
    cmd_o.status = collecting_q && (idx_q == STATUS_POS);
    cmd_o.weight = collecting_q && (idx_q >= WEIGHT_FIRST) && (idx_q <= WEIGHT_LAST);
    cmd_o.tare   = collecting_q && (idx_q >= TARE_FIRST) && (idx_q <= TARE_LAST);
    cmd_o.last   = collecting_q && (idx_q >= LAST_POS);
    cmd_push_o   = take_i && (collecting_q || is_stx);

    collecting_d = collecting_q;
    idx_d        = idx_q;
    if (take_i) begin
      if (!collecting_q) begin
        if (is_stx) begin
          collecting_d = 1'b1;
          idx_d        = IDX_W'(1);
        end
      end else if (cmd_o.last) begin
        collecting_d = 1'b0;
        idx_d        = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      idx_q        <= '0;
    end else begin
      collecting_q <= collecting_d;
      idx_q        <= idx_d;
    end
  end

endmodule

// File: rtl/sfp_back.sv
`timescale 1ns / 1ps
// Back end: applies tagged bytes to the sum, status and digit registers
// and builds one result at the last byte. Depends on sfp_pkg.
module sfp_back
  import sfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  logic [6:0]  sum_q, sum_d;
  logic [15:0] bad_q, bad_d;
  logic [7:0]  status_q, status_d;
  logic [47:0] weight_q, weight_d;
  logic [47:0] tare_q, tare_d;
  logic        bad;
  logic        rej;

  assign cmd_pop_o  = cmd_valid_i && (!cmd_i.last || !res_full_i);
  assign res_push_o = cmd_valid_i && cmd_i.last && !res_full_i;

  always_comb begin
    sum_d    = cmd_i.start ? cmd_i.data[6:0] : sum_q + cmd_i.data[6:0];
    status_d = cmd_i.status ? cmd_i.data : status_q;
    weight_d = cmd_i.weight ? {weight_q[39:0], cmd_i.data} : weight_q;
    tare_d   = cmd_i.tare ? {tare_q[39:0], cmd_i.data} : tare_q;
    bad      = (sum_d != '0);
    bad_d    = (cmd_i.last && bad) ? bad_q + 1'b1 : bad_q;
    rej      = is_rejected(status_d);

    res_o.sum7           = sum_d;
    res_o.checksum_bad   = bad;
    res_o.bad_frames     = bad_d;
    res_o.frame_rejected = rej;
    res_o.unit_code      = unit_of(status_d);
    res_o.weight_digits  = rej ? '0 : weight_d;
    res_o.tare_digits    = rej ? '0 : tare_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      bad_q <= '0;
    end else if (cmd_pop_o) begin
      sum_q <= cmd_i.last ? '0 : sum_d;
      bad_q <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      status_q <= status_d;
      weight_q <= weight_d;
      tare_q   <= tare_d;
    end
  end

endmodule

// File: rtl/scale_frame_parser_unit.sv
`timescale 1ns / 1ps
// Scale frame parser: accepts one received byte per cycle while the command queue
// has room, one result per frame. A frame's result is registered in the command
// queue and then in the result queue, two entries each, before it can be popped
// from the result ports.
// A full result queue holds back only the last byte of a frame.
// Reset (async, active low) returns to hunting and clears sums and counters.
module scale_frame_parser_unit
  import sfp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic [6:0]  sum7_o,
  output logic        checksum_bad_o,
  output logic [15:0] bad_frames_o,
  output logic        frame_rejected_o,
  output logic [1:0]  unit_code_o,
  output logic [47:0] weight_digits_o,
  output logic [47:0] tare_digits_o
);

  localparam int unsigned CMD_W = $bits(cmd_t);
  localparam int unsigned RES_W = $bits(res_t);

  logic             take;
  logic             cmd_push, cmd_pop, cmd_empty;
  cmd_t             cmd_in;
  logic [CMD_W-1:0] cmd_raw;
  logic             res_push, res_full;
  res_t             res_in, res_out;
  logic [RES_W-1:0] res_raw;

  assign take = push && !full;

  sfp_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .rx_byte_i (rx_byte_i),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_in)
  );

  sfp_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(2)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_raw),
    .empty_o(cmd_empty)
  );

  sfp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (cmd_t'(cmd_raw)),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  sfp_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_raw),
    .empty_o(empty)
  );

  assign res_out          = res_t'(res_raw);
  assign sum7_o           = res_out.sum7;
  assign checksum_bad_o   = res_out.checksum_bad;
  assign bad_frames_o     = res_out.bad_frames;
  assign frame_rejected_o = res_out.frame_rejected;
  assign unit_code_o      = res_out.unit_code;
  assign weight_digits_o  = res_out.weight_digits;
  assign tare_digits_o    = res_out.tare_digits;

  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_cmd_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from an empty queue");

  a_bad_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (checksum_bad_o == (sum7_o != '0)))
    else $error("checksum flag disagrees with sum");

  a_reject_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_rejected_o) |-> (unit_code_o == UNIT_KEEP))
    else $error("rejected frame carries a unit change");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench for scale_frame_parser_unit: random and directed byte streams in, frame results out.
// Depends on sfp_pkg and the parser RTL; a scoreboard class predicts each frame result.
module tb
  import sfp_pkg::*;
();

  localparam int FRAME_LEN   = 18;
  localparam int BYTE_TARGET = 1600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        pop = 1'b0;
  logic        empty;
  logic [6:0]  sum7_o;
  logic        checksum_bad_o;
  logic [15:0] bad_frames_o;
  logic        frame_rejected_o;
  logic [1:0]  unit_code_o;
  logic [47:0] weight_digits_o;
  logic [47:0] tare_digits_o;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          frame_bytes_sent = 0;
  logic [7:0]  frame_buf [FRAME_LEN];

  class frame_scoreboard;
    logic        collecting = 1'b0;
    logic [4:0]  idx = '0;
    logic [6:0]  run_sum = '0;
    logic [7:0]  status = '0;
    logic [47:0] weight = '0;
    logic [47:0] tare = '0;
    logic [15:0] bad_count = '0;
    res_t        pending_frames[$];
    int          mismatches = 0;

    task report(string what, logic [47:0] got, logic [47:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatches++;
    endtask

    function void note_byte(logic [7:0] b);
      res_t r;
      logic rej;
      if (!collecting) begin
        if (b == STX_BYTE) begin
          collecting = 1'b1;
          run_sum = b[6:0];
          idx = 5'd1;
        end
        return;
      end
      run_sum = run_sum + b[6:0];
      if (idx == STATUS_POS) status = b;
      if (idx >= WEIGHT_FIRST && idx <= WEIGHT_LAST) weight = {weight[39:0], b};
      if (idx >= TARE_FIRST && idx <= TARE_LAST) tare = {tare[39:0], b};
      if (int'(idx) + 1 < FRAME_LEN) begin
        idx = idx + 5'd1;
        return;
      end
      if (run_sum != 7'd0) bad_count = bad_count + 16'd1;
      rej = (status == ST_MOTION_A) || (status == ST_MOTION_B) ||
            (status == ST_OVER_A) || (status == ST_OVER_B);
      r.sum7 = run_sum;
      r.checksum_bad = (run_sum != 7'd0);
      r.bad_frames = bad_count;
      r.frame_rejected = rej;
      r.unit_code = (status == ST_POUNDS) ? UNIT_LB : (status == ST_KILOS) ? UNIT_KG : UNIT_KEEP;
      r.weight_digits = rej ? 48'd0 : weight;
      r.tare_digits = rej ? 48'd0 : tare;
      pending_frames.push_back(r);
      collecting = 1'b0;
      idx = '0;
      run_sum = '0;
    endfunction

    task check_frame(res_t got);
      res_t want;
      if (pending_frames.size() == 0) begin
        report("unexpected frame result", 48'd0, 48'd0);
        return;
      end
      want = pending_frames.pop_front();
      if (got.sum7 !== want.sum7) report("sum7", got.sum7, want.sum7);
      if (got.checksum_bad !== want.checksum_bad)
        report("checksum_bad", got.checksum_bad, want.checksum_bad);
      if (got.bad_frames !== want.bad_frames) report("bad_frames", got.bad_frames, want.bad_frames);
      if (got.frame_rejected !== want.frame_rejected)
        report("frame_rejected", got.frame_rejected, want.frame_rejected);
      if (got.unit_code !== want.unit_code) report("unit_code", got.unit_code, want.unit_code);
      if (got.weight_digits !== want.weight_digits)
        report("weight_digits", got.weight_digits, want.weight_digits);
      if (got.tare_digits !== want.tare_digits)
        report("tare_digits", got.tare_digits, want.tare_digits);
    endtask
  endclass

  frame_scoreboard sb = new();

  scale_frame_parser_unit #(.FRAME_BYTES(FRAME_LEN)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .rx_byte_i(rx_byte_i),
    .pop(pop),
    .empty(empty),
    .sum7_o(sum7_o),
    .checksum_bad_o(checksum_bad_o),
    .bad_frames_o(bad_frames_o),
    .frame_rejected_o(frame_rejected_o),
    .unit_code_o(unit_code_o),
    .weight_digits_o(weight_digits_o),
    .tare_digits_o(tare_digits_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("scale_frame_parser_unit verification failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_byte(b);
  endtask

  // When fix_sum is set, fix the last byte so the 7-bit frame sum comes out zero.
  task automatic send_frame(input bit fix_sum);
    logic [6:0] s;
    s = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) s = s + frame_buf[i][6:0];
    if (fix_sum) frame_buf[FRAME_LEN-1] = {frame_buf[FRAME_LEN-1][7], 7'd0 - s};
    for (int i = 0; i < FRAME_LEN; i++) send_byte(frame_buf[i]);
    frame_bytes_sent += FRAME_LEN;
  endtask

  task automatic fill_random_frame();
    bit ascii;
    ascii = ($urandom_range(99) < 75);
    frame_buf[0] = STX_BYTE;
    for (int i = 1; i < FRAME_LEN; i++) frame_buf[i] = 8'($urandom_range(255));
    case ($urandom_range(7))
      0: frame_buf[STATUS_POS] = ST_POUNDS;
      1: frame_buf[STATUS_POS] = ST_KILOS;
      2: frame_buf[STATUS_POS] = ST_MOTION_A;
      3: frame_buf[STATUS_POS] = ST_MOTION_B;
      4: frame_buf[STATUS_POS] = ST_OVER_A;
      5: frame_buf[STATUS_POS] = ST_OVER_B;
      default: ;
    endcase
    if (ascii) begin
      for (int i = WEIGHT_FIRST; i <= TARE_LAST; i++) begin
        frame_buf[i] = 8'h30 + 8'($urandom_range(9));
      end
    end
  endtask

  initial begin
    wait (rst_ni);
    forever begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk_i);
      if (pop && !empty) begin
        sb.check_frame('{sum7: sum7_o, checksum_bad: checksum_bad_o, bad_frames: bad_frames_o,
                         frame_rejected: frame_rejected_o, unit_code: unit_code_o,
                         weight_digits: weight_digits_o, tare_digits: tare_digits_o});
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 10;
    recv_idle_pct = 65;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h80);
    frame_buf = '{STX_BYTE, 8'hFF, ST_POUNDS, STX_BYTE, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h30,
                  8'h39, 8'h39, 8'h38, 8'h37, 8'h36, 8'h35, 8'h34, 8'h00, 8'h00};
    send_frame(1'b1);

    while (frame_bytes_sent < BYTE_TARGET) begin
      if (frame_bytes_sent < BYTE_TARGET / 3) begin
        send_idle_pct = 10;
        recv_idle_pct = 65;
      end else if (frame_bytes_sent < 2 * BYTE_TARGET / 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(99) < 80) begin
        fill_random_frame();
        send_frame($urandom_range(99) < 60);
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end
    end
    push <= 1'b0;

    while (sb.pending_frames.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("scale_frame_parser_unit verification clean");
    end else begin
      $display("scale_frame_parser_unit verification failed");
    end
    $finish;
  end

endmodule
